// File: rtl/mazemap_pkg.sv
`timescale 1ns / 1ps

package mazemap_pkg;

    typedef logic [3:0] walls_t;

    typedef enum logic [2:0] {
        OP_SENSE   = 3'd0,
        OP_FORWARD = 3'd1,
        OP_LEFT    = 3'd2,
        OP_RIGHT   = 3'd3,
        OP_AROUND  = 3'd4,
        OP_HOLD    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_QRY,
        ST_DONE,
        ST_OUT
    } state_t;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    localparam logic [1:0] TURN_LEFT   = 2'd3;
    localparam logic [1:0] TURN_RIGHT  = 2'd1;
    localparam logic [1:0] TURN_AROUND = 2'd2;

    localparam logic [11:0] THRESHOLD_RESET = 12'd140;

endpackage

// File: rtl/maze_wall_map_with_pose_top.sv
`timescale 1ns / 1ps

// Channel   Signals                                             Handshake
// --------  --------------------------------------------------  ------------------------
// cfg       wall_threshold_mm                                   cfg_valid / cfg_ready
// in        operation, front_mm, left_mm, right_mm,             in_valid / in_stall
//           query_x, query_y, query_dir
// out       pos_x, pos_y, facing, cell_walls, query_wall,       out_valid / out_stall
//           move_blocked
//
// A move, turn or hold goes through the QRY and DONE states to a loaded result; a sense command
// first makes its four read-modify-writes in RMW, through the wall memory's one read and one write port.
// After reset all GRID_SIDE*GRID_SIDE wall memory entries (256 by default) are cleared in turn
// while in_stall stays high; configuration writes are taken at any time.
// A finished result waits in the output register while the next command is accepted;
// a result that finds that register still full holds the block until out_stall drops.

module maze_wall_map_with_pose_top #(
    parameter int GRID_SIDE = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] wall_threshold_mm,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [11:0] front_mm,
    input  logic [11:0] left_mm,
    input  logic [11:0] right_mm,
    input  logic [3:0]  query_x,
    input  logic [3:0]  query_y,
    input  logic [1:0]  query_dir,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  pos_x,
    output logic [3:0]  pos_y,
    output logic [1:0]  facing,
    output logic [3:0]  cell_walls,
    output logic        query_wall,
    output logic        move_blocked
);

    localparam int PW    = $clog2(GRID_SIDE);
    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);

    typedef logic [PW-1:0] coord_t;
    typedef logic [AW-1:0] addr_t;

    typedef struct packed {
        addr_t                addr;
        mazemap_pkg::walls_t  mask;
        logic                 en;
    } step_t;

    function automatic addr_t cell_addr(coord_t x, coord_t y);
        cell_addr = AW'(AW'(y) * AW'(GRID_SIDE) + AW'(x));
    endfunction

    function automatic logic at_edge(coord_t x, coord_t y, logic [1:0] d);
        logic edge_hit;
        unique case (d)
            mazemap_pkg::DIR_NORTH: edge_hit = (y == PW'(GRID_SIDE - 1));
            mazemap_pkg::DIR_EAST:  edge_hit = (x == PW'(GRID_SIDE - 1));
            mazemap_pkg::DIR_SOUTH: edge_hit = (y == '0);
            mazemap_pkg::DIR_WEST:  edge_hit = (x == '0);
        endcase
        at_edge = edge_hit;
    endfunction

    function automatic coord_t step_x(coord_t x, logic [1:0] d);
        unique case (d)
            mazemap_pkg::DIR_EAST: step_x = x + PW'(1);
            mazemap_pkg::DIR_WEST: step_x = x - PW'(1);
            default:               step_x = x;
        endcase
    endfunction

    function automatic coord_t step_y(coord_t y, logic [1:0] d);
        unique case (d)
            mazemap_pkg::DIR_NORTH: step_y = y + PW'(1);
            mazemap_pkg::DIR_SOUTH: step_y = y - PW'(1);
            default:                step_y = y;
        endcase
    endfunction

    function automatic step_t neighbor_step(coord_t x, coord_t y, logic [1:0] d, logic mark);
        step_t s;
        logic [1:0] opp;
        opp    = d + mazemap_pkg::TURN_AROUND;
        s.addr = cell_addr(step_x(x, d), step_y(y, d));
        s.mask = mazemap_pkg::walls_t'(4'b0001 << opp);
        s.en   = mark && !at_edge(x, y, d);
        neighbor_step = s;
    endfunction

    mazemap_pkg::state_t  state_reg, state_next;
    addr_t                clr_reg, clr_next;
    coord_t               px_reg, px_next;
    coord_t               py_reg, py_next;
    logic [1:0]           head_reg, head_next;
    logic [11:0]          thr_reg;
    logic [1:0]           cnt_reg, cnt_next;
    step_t                queue_reg [4];
    step_t                queue_next [4];
    step_t                pend_reg, pend_next;
    addr_t                qaddr_reg, qaddr_next;
    logic [1:0]           qdir_reg, qdir_next;
    logic                 qin_reg, qin_next;
    mazemap_pkg::walls_t  cur_reg, cur_next;
    logic                 qbit_reg, qbit_next;
    logic                 blocked_reg, blocked_next;

    logic                 out_valid_reg, out_valid_next;
    logic [3:0]           out_px_reg, out_px_next;
    logic [3:0]           out_py_reg, out_py_next;
    logic [1:0]           out_head_reg, out_head_next;
    mazemap_pkg::walls_t  out_walls_reg, out_walls_next;
    logic                 out_qw_reg, out_qw_next;
    logic                 out_blk_reg, out_blk_next;

    mazemap_pkg::walls_t  mem [DEPTH];
    mazemap_pkg::walls_t  mem_rdata_reg;
    mazemap_pkg::walls_t  fwd_data_reg;
    logic                 fwd_hit_reg;
    mazemap_pkg::walls_t  rd_walls;
    addr_t                rd_addr;
    logic                 wr_en;
    addr_t                wr_addr;
    mazemap_pkg::walls_t  wr_data;

    logic                 mk_front, mk_left, mk_right;
    logic [1:0]           dir_left, dir_right;
    mazemap_pkg::walls_t  cur_mask;
    step_t                cur_step;
    logic                 out_free;
    logic                 qbit_now;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != mazemap_pkg::ST_IDLE);
    assign rd_walls  = fwd_hit_reg ? fwd_data_reg : mem_rdata_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign qbit_now  = qin_reg && rd_walls[qdir_reg];

    assign mk_front  = (front_mm < thr_reg);
    assign mk_left   = (left_mm < thr_reg);
    assign mk_right  = (right_mm < thr_reg);
    assign dir_left  = head_reg + mazemap_pkg::TURN_LEFT;
    assign dir_right = head_reg + mazemap_pkg::TURN_RIGHT;

    assign cur_mask  = (mk_front ? mazemap_pkg::walls_t'(4'b0001 << head_reg) : 4'b0000)
                     | (mk_left  ? mazemap_pkg::walls_t'(4'b0001 << dir_left) : 4'b0000)
                     | (mk_right ? mazemap_pkg::walls_t'(4'b0001 << dir_right) : 4'b0000);
    assign cur_step  = '{addr: cell_addr(px_reg, py_reg), mask: cur_mask, en: |cur_mask};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        queue_next     = queue_reg;
        pend_next      = pend_reg;
        qaddr_next     = qaddr_reg;
        qdir_next      = qdir_reg;
        qin_next       = qin_reg;
        cur_next       = cur_reg;
        qbit_next      = qbit_reg;
        blocked_next   = blocked_reg;
        out_valid_next = out_valid_reg;
        out_px_next    = out_px_reg;
        out_py_next    = out_py_reg;
        out_head_next  = out_head_reg;
        out_walls_next = out_walls_reg;
        out_qw_next    = out_qw_reg;
        out_blk_next   = out_blk_reg;
        rd_addr        = cell_addr(px_reg, py_reg);
        wr_en          = 1'b0;
        wr_addr        = pend_reg.addr;
        wr_data        = rd_walls | pend_reg.mask;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            mazemap_pkg::ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = mazemap_pkg::ST_IDLE;
                end
            end
            mazemap_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    qaddr_next   = cell_addr(PW'(query_x), PW'(query_y));
                    qdir_next    = query_dir;
                    qin_next     = (32'(query_x) < GRID_SIDE) && (32'(query_y) < GRID_SIDE);
                    blocked_next = 1'b0;
                    pend_next    = '{addr: cell_addr(px_reg, py_reg), mask: '0, en: 1'b0};
                    state_next   = mazemap_pkg::ST_QRY;
                    unique case (mazemap_pkg::op_t'(operation))
                        mazemap_pkg::OP_SENSE:
                        begin
                            pend_next     = cur_step;
                            queue_next[0] = neighbor_step(px_reg, py_reg, head_reg, mk_front);
                            queue_next[1] = neighbor_step(px_reg, py_reg, dir_left, mk_left);
                            queue_next[2] = neighbor_step(px_reg, py_reg, dir_right, mk_right);
                            queue_next[3] = '{addr: cell_addr(px_reg, py_reg), mask: '0,
                                              en: 1'b0};
                            cnt_next      = '0;
                            state_next    = mazemap_pkg::ST_RMW;
                        end
                        mazemap_pkg::OP_FORWARD:
                        begin
                            if (at_edge(px_reg, py_reg, head_reg))
                            begin
                                blocked_next = 1'b1;
                            end
                            else
                            begin
                                px_next = step_x(px_reg, head_reg);
                                py_next = step_y(py_reg, head_reg);
                                rd_addr = cell_addr(step_x(px_reg, head_reg),
                                                    step_y(py_reg, head_reg));
                            end
                        end
                        mazemap_pkg::OP_LEFT:
                        begin
                            head_next = head_reg + mazemap_pkg::TURN_LEFT;
                        end
                        mazemap_pkg::OP_RIGHT:
                        begin
                            head_next = head_reg + mazemap_pkg::TURN_RIGHT;
                        end
                        mazemap_pkg::OP_AROUND:
                        begin
                            head_next = head_reg + mazemap_pkg::TURN_AROUND;
                        end
                        default:
                        begin
                            head_next = head_reg;
                        end
                    endcase
                end
            end
            mazemap_pkg::ST_RMW:
            begin
                rd_addr       = queue_reg[0].addr;
                wr_en         = pend_reg.en;
                pend_next     = queue_reg[0];
                queue_next[0] = queue_reg[1];
                queue_next[1] = queue_reg[2];
                queue_next[2] = queue_reg[3];
                cnt_next      = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = mazemap_pkg::ST_QRY;
                end
            end
            mazemap_pkg::ST_QRY:
            begin
                rd_addr    = qaddr_reg;
                cur_next   = rd_walls;
                state_next = mazemap_pkg::ST_DONE;
            end
            mazemap_pkg::ST_DONE:
            begin
                qbit_next  = qbit_now;
                state_next = mazemap_pkg::ST_OUT;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_px_next    = 4'(px_reg);
                    out_py_next    = 4'(py_reg);
                    out_head_next  = head_reg;
                    out_walls_next = cur_reg;
                    out_qw_next    = qbit_now;
                    out_blk_next   = blocked_reg;
                    state_next     = mazemap_pkg::ST_IDLE;
                end
            end
            mazemap_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_px_next    = 4'(px_reg);
                    out_py_next    = 4'(py_reg);
                    out_head_next  = head_reg;
                    out_walls_next = cur_reg;
                    out_qw_next    = qbit_reg;
                    out_blk_next   = blocked_reg;
                    state_next     = mazemap_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mazemap_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mazemap_pkg::ST_CLEAR;
            clr_reg       <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            head_reg      <= mazemap_pkg::DIR_NORTH;
            thr_reg       <= mazemap_pkg::THRESHOLD_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= wall_threshold_mm;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        queue_reg     <= queue_next;
        pend_reg      <= pend_next;
        qaddr_reg     <= qaddr_next;
        qdir_reg      <= qdir_next;
        qin_reg       <= qin_next;
        cur_reg       <= cur_next;
        qbit_reg      <= qbit_next;
        blocked_reg   <= blocked_next;
        out_px_reg    <= out_px_next;
        out_py_reg    <= out_py_next;
        out_head_reg  <= out_head_next;
        out_walls_reg <= out_walls_next;
        out_qw_reg    <= out_qw_next;
        out_blk_reg   <= out_blk_next;
    end

    // A read of the entry written in the same cycle returns the new value.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_rdata_reg <= mem[rd_addr];
        fwd_hit_reg   <= wr_en && (wr_addr == rd_addr);
        fwd_data_reg  <= wr_data;
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = out_px_reg;
    assign pos_y        = out_py_reg;
    assign facing       = out_head_reg;
    assign cell_walls   = out_walls_reg;
    assign query_wall   = out_qw_reg;
    assign move_blocked = out_blk_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int GRID_SIDE = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [2:0] OP_RESERVED_LO = 3'd6;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic [3:0]          pos_x;
        logic [3:0]          pos_y;
        logic [1:0]          facing;
        mazemap_pkg::walls_t cell_walls;
        logic                query_wall;
        logic                move_blocked;
    } pose_report_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [11:0] wall_threshold_mm = mazemap_pkg::THRESHOLD_RESET;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  operation = mazemap_pkg::OP_HOLD;
    logic [11:0] front_mm = '0;
    logic [11:0] left_mm = '0;
    logic [11:0] right_mm = '0;
    logic [3:0]  query_x = '0;
    logic [3:0]  query_y = '0;
    logic [1:0]  query_dir = mazemap_pkg::DIR_NORTH;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  pos_x;
    logic [3:0]  pos_y;
    logic [1:0]  facing;
    logic [3:0]  cell_walls;
    logic        query_wall;
    logic        move_blocked;

    mazemap_pkg::walls_t known_walls [GRID_SIDE * GRID_SIDE];
    logic [3:0]   bot_x;
    logic [3:0]   bot_y;
    logic [1:0]   bot_heading;
    logic [11:0]  threshold_mm;
    pose_report_t expected_reports [$];
    int           mismatch_count = 0;
    bit           tx_steady = 1'b0;
    bit           rx_steady = 1'b0;
    int           hold_request = 0;

    maze_wall_map_with_pose_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .wall_threshold_mm (wall_threshold_mm),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .operation         (operation),
        .front_mm          (front_mm),
        .left_mm           (left_mm),
        .right_mm          (right_mm),
        .query_x           (query_x),
        .query_y           (query_y),
        .query_dir         (query_dir),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .facing            (facing),
        .cell_walls        (cell_walls),
        .query_wall        (query_wall),
        .move_blocked      (move_blocked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int step_x(input logic [1:0] dir);
        if (dir == mazemap_pkg::DIR_EAST)
            return 1;
        if (dir == mazemap_pkg::DIR_WEST)
            return -1;
        return 0;
    endfunction

    function automatic int step_y(input logic [1:0] dir);
        if (dir == mazemap_pkg::DIR_NORTH)
            return 1;
        if (dir == mazemap_pkg::DIR_SOUTH)
            return -1;
        return 0;
    endfunction

    function automatic bit on_grid(input int x, input int y);
        return x >= 0 && x < GRID_SIDE && y >= 0 && y < GRID_SIDE;
    endfunction

    task automatic mark_side(input logic [1:0] dir);
        int nx;
        int ny;
        logic [1:0] opposite;
        known_walls[int'(bot_y) * GRID_SIDE + int'(bot_x)][dir] = 1'b1;
        nx = int'(bot_x) + step_x(dir);
        ny = int'(bot_y) + step_y(dir);
        opposite = dir + mazemap_pkg::TURN_AROUND;
        if (on_grid(nx, ny))
            known_walls[ny * GRID_SIDE + nx][opposite] = 1'b1;
    endtask

    task automatic predict_pose(input logic [2:0] op, input logic [11:0] f,
                                input logic [11:0] l, input logic [11:0] r,
                                input logic [3:0] qx, input logic [3:0] qy,
                                input logic [1:0] qd);
        pose_report_t rep;
        int nx;
        int ny;
        logic [1:0] side;
        rep.move_blocked = 1'b0;
        case (op)
            mazemap_pkg::OP_SENSE:
            begin
                if (f < threshold_mm)
                    mark_side(bot_heading);
                side = bot_heading + mazemap_pkg::TURN_LEFT;
                if (l < threshold_mm)
                    mark_side(side);
                side = bot_heading + mazemap_pkg::TURN_RIGHT;
                if (r < threshold_mm)
                    mark_side(side);
            end
            mazemap_pkg::OP_FORWARD:
            begin
                nx = int'(bot_x) + step_x(bot_heading);
                ny = int'(bot_y) + step_y(bot_heading);
                if (on_grid(nx, ny))
                begin
                    bot_x = nx[3:0];
                    bot_y = ny[3:0];
                end
                else
                begin
                    rep.move_blocked = 1'b1;
                end
            end
            mazemap_pkg::OP_LEFT:   bot_heading = bot_heading + mazemap_pkg::TURN_LEFT;
            mazemap_pkg::OP_RIGHT:  bot_heading = bot_heading + mazemap_pkg::TURN_RIGHT;
            mazemap_pkg::OP_AROUND: bot_heading = bot_heading + mazemap_pkg::TURN_AROUND;
            default:   ;
        endcase
        rep.pos_x = bot_x;
        rep.pos_y = bot_y;
        rep.facing = bot_heading;
        rep.cell_walls = known_walls[int'(bot_y) * GRID_SIDE + int'(bot_x)];
        rep.query_wall = known_walls[int'(qy) * GRID_SIDE + int'(qx)][qd];
        expected_reports.push_back(rep);
    endtask

    task automatic send_command(input logic [2:0] op, input logic [11:0] f,
                                input logic [11:0] l, input logic [11:0] r,
                                input logic [3:0] qx, input logic [3:0] qy,
                                input logic [1:0] qd);
        if (!tx_steady)
        begin
            while ($urandom_range(99) < 33)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        operation <= op;
        front_mm <= f;
        left_mm <= l;
        right_mm <= r;
        query_x <= qx;
        query_y <= qy;
        query_dir <= qd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pose(op, f, l, r, qx, qy, qd);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [11:0] value);
        cfg_valid <= 1'b1;
        wall_threshold_mm <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        threshold_mm = value;
    endtask

    function automatic logic [11:0] pick_distance();
        case ($urandom_range(7))
            0:       return (threshold_mm == 0) ? 12'd0 : 12'($urandom_range(threshold_mm - 1));
            1:       return threshold_mm;
            2:       return (threshold_mm == 0) ? 12'd0 : threshold_mm - 12'd1;
            3:       return (threshold_mm == 12'hFFF) ? 12'hFFF : threshold_mm + 12'd1;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    task automatic send_random_command();
        int pick;
        logic [2:0] op;
        logic [3:0] qx;
        logic [3:0] qy;
        pick = $urandom_range(99);
        if (pick < 35)
            op = mazemap_pkg::OP_SENSE;
        else if (pick < 65)
            op = mazemap_pkg::OP_FORWARD;
        else if (pick < 75)
            op = mazemap_pkg::OP_LEFT;
        else if (pick < 85)
            op = mazemap_pkg::OP_RIGHT;
        else if (pick < 90)
            op = mazemap_pkg::OP_AROUND;
        else if (pick < 95)
            op = mazemap_pkg::OP_HOLD;
        else
            op = $urandom_range(1) ? OP_RESERVED_HI : OP_RESERVED_LO;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            qx = bot_x;
            qy = bot_y;
        end
        else if (pick < 65)
        begin
            qx = bot_x + 4'd1;
            qy = bot_y;
        end
        else if (pick < 80)
        begin
            qx = bot_x;
            qy = bot_y + 4'd1;
        end
        else
        begin
            qx = 4'($urandom_range(15));
            qy = 4'($urandom_range(15));
        end
        send_command(op, pick_distance(), pick_distance(), pick_distance(), qx, qy,
                     2'($urandom_range(3)));
    endtask

    task automatic run_random_commands(input int count);
        repeat (count)
            send_random_command();
    endtask

    task automatic test_reset_state();
        write_threshold(mazemap_pkg::THRESHOLD_RESET);
        send_command(mazemap_pkg::OP_HOLD, 12'd0, 12'd0, 12'd0, 4'd0, 4'd0,
                     mazemap_pkg::DIR_NORTH);
        send_command(OP_RESERVED_LO, 12'd0, 12'd0, 12'd0, 4'd15, 4'd15,
                     mazemap_pkg::DIR_WEST);
        send_command(OP_RESERVED_HI, 12'hFFF, 12'hFFF, 12'hFFF, 4'd15, 4'd0,
                     mazemap_pkg::DIR_EAST);
    endtask

    task automatic test_turns_and_edges();
        send_command(mazemap_pkg::OP_AROUND, 12'd0, 12'd0, 12'd0, 4'd0, 4'd0,
                     mazemap_pkg::DIR_SOUTH);
        send_command(mazemap_pkg::OP_FORWARD, 12'd0, 12'd0, 12'd0, 4'd0, 4'd0,
                     mazemap_pkg::DIR_SOUTH);
        send_command(mazemap_pkg::OP_RIGHT, 12'd0, 12'd0, 12'd0, 4'd0, 4'd0,
                     mazemap_pkg::DIR_WEST);
        send_command(mazemap_pkg::OP_FORWARD, 12'd0, 12'd0, 12'd0, 4'd0, 4'd0,
                     mazemap_pkg::DIR_WEST);
        send_command(mazemap_pkg::OP_LEFT, 12'd0, 12'd0, 12'd0, 4'd0, 4'd0,
                     mazemap_pkg::DIR_NORTH);
        send_command(mazemap_pkg::OP_LEFT, 12'd0, 12'd0, 12'd0, 4'd0, 4'd0,
                     mazemap_pkg::DIR_NORTH);
        send_command(mazemap_pkg::OP_FORWARD, 12'd0, 12'd0, 12'd0, 4'd1, 4'd0,
                     mazemap_pkg::DIR_EAST);
        send_command(mazemap_pkg::OP_AROUND, 12'd0, 12'd0, 12'd0, 4'd1, 4'd0,
                     mazemap_pkg::DIR_EAST);
        send_command(mazemap_pkg::OP_FORWARD, 12'd0, 12'd0, 12'd0, 4'd0, 4'd0,
                     mazemap_pkg::DIR_NORTH);
        send_command(mazemap_pkg::OP_RIGHT, 12'd0, 12'd0, 12'd0, 4'd0, 4'd0,
                     mazemap_pkg::DIR_NORTH);
    endtask

    task automatic test_sense_marking();
        // Front just below the threshold, right exactly at it; left faces off the grid.
        send_command(mazemap_pkg::OP_SENSE, mazemap_pkg::THRESHOLD_RESET - 12'd1, 12'd0,
                     mazemap_pkg::THRESHOLD_RESET, 4'd0, 4'd1, mazemap_pkg::DIR_SOUTH);
        send_command(mazemap_pkg::OP_SENSE, 12'hFFF, 12'hFFF,
                     mazemap_pkg::THRESHOLD_RESET - 12'd1, 4'd1, 4'd0,
                     mazemap_pkg::DIR_WEST);
    endtask

    task automatic test_threshold_extremes();
        wait_for_results();
        write_threshold(12'd0);
        send_command(mazemap_pkg::OP_SENSE, 12'd0, 12'd0, 12'd0, 4'd0, 4'd0,
                     mazemap_pkg::DIR_EAST);
        wait_for_results();
        write_threshold(12'hFFF);
        send_command(mazemap_pkg::OP_AROUND, 12'd0, 12'd0, 12'd0, 4'd15, 4'd15,
                     mazemap_pkg::DIR_WEST);
        send_command(mazemap_pkg::OP_SENSE, 12'hFFE, 12'hFFF, 12'hFFF, 4'd0, 4'd0,
                     mazemap_pkg::DIR_SOUTH);
        wait_for_results();
        write_threshold(mazemap_pkg::THRESHOLD_RESET);
    endtask

    task automatic test_output_holdoff();
        wait_for_results();
        hold_request <= hold_request + 1;
        run_random_commands(40);
        wait_for_results();
    endtask

    task automatic test_random_walk();
        run_random_commands(470);
        wait_for_results();
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        run_random_commands(150);
        wait_for_results();
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
        write_threshold(12'($urandom_range(4095)));
        run_random_commands(350);
        wait_for_results();
        write_threshold(12'hFFF);
        run_random_commands(200);
        wait_for_results();
        write_threshold(12'd0);
        run_random_commands(100);
        wait_for_results();
        write_threshold(12'd1);
        run_random_commands(120);
    endtask

    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != hold_seen)
            begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (rx_steady)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < 33);
            end
        end
    end

    task automatic check_field(input string label, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin : report_checker
        pose_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected transaction, expected none, got pos (%0d,%0d)",
                         $time, pos_x, pos_y);
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("pos_x", want.pos_x, pos_x);
                check_field("pos_y", want.pos_y, pos_y);
                check_field("facing", {2'b00, want.facing}, {2'b00, facing});
                check_field("cell_walls", want.cell_walls, cell_walls);
                check_field("query_wall", {3'b000, want.query_wall}, {3'b000, query_wall});
                check_field("move_blocked", {3'b000, want.move_blocked},
                            {3'b000, move_blocked});
            end
        end
    end

    initial
    begin
        foreach (known_walls[i])
            known_walls[i] = '0;
        bot_x = '0;
        bot_y = '0;
        bot_heading = mazemap_pkg::DIR_NORTH;
        threshold_mm = mazemap_pkg::THRESHOLD_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_turns_and_edges();
        test_sense_marking();
        test_threshold_extremes();
        test_output_holdoff();
        test_random_walk();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
